// File: hw/rtl/rcpwm_pkg.sv
// rcpwm_pkg: shared types and constants of the rc pwm duty capture block
`timescale 1ns / 1ps
package rcpwm_pkg;

  localparam int FRAC_W = 16;
  localparam int DUTY_W = 15;
  localparam int CH_IN_W = 2;
  localparam int MASK_W = 4;
  localparam int CFG_IDX_W = 2;

  // serial step counts: one fraction bit per multiply step, one quotient bit per divide step
  localparam int MUL_STEPS = FRAC_W;
  localparam int DIV_STEPS = DUTY_W;
  localparam int CNT_W = 4;

  localparam logic [DUTY_W-1:0] FULL_SCALE = 15'd25600;

  localparam logic [FRAC_W-1:0] MIN_FRAC_RST = 16'd3277;
  localparam logic [FRAC_W-1:0] SPAN_FRAC_RST = 16'd3277;
  localparam logic [MASK_W-1:0] INVERT_RST = 4'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_FRAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// File: hw/rtl/rc_pwm_duty_capture.sv
// rc_pwm_duty_capture: rc receiver pwm duty decoder with serial multiply and divide
//
//   channel   signals                                   direction
//   in_       in_valid in_stall in_channel in_tick      request in
//             in_level_high
//   out_      out_valid out_stall out_channel out_duty  result out
//   cfg_      cfg_valid cfg_ready cfg_index cfg_data    register write in
//
// a rising edge runs 1 capture, 16 shift-add multiply steps (one fraction
// bit each), 1 prep, 15 restoring divide steps (one quotient bit each), 1 emit
// a saturated or zero-span result skips the divide
// falling edges and channels at or above NUM_CHANNELS are taken while idle and give no result
// reset clears the capture registers and loads the fraction and invert defaults
// a stalled output holds the block in emit; no request is taken until the result moves
`timescale 1ns / 1ps
module rc_pwm_duty_capture #(
  parameter int NUM_CHANNELS = 4,
  parameter int TICK_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rcpwm_pkg::CH_IN_W-1:0]       in_channel,
  input  logic [31:0]                         in_tick,
  input  logic                                in_level_high,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rcpwm_pkg::CH_IN_W-1:0]       out_channel,
  output logic [rcpwm_pkg::DUTY_W-1:0]        out_duty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcpwm_pkg::FRAC_W-1:0]        cfg_data
);
  import rcpwm_pkg::*;

  localparam int TW = TICK_BITS;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ACC_W = TW + FRAC_W;
  localparam int DIVD_W = TW + DUTY_W;

  state_t state_r, state_nxt;

  logic [FRAC_W-1:0] min_frac_r, span_frac_r;
  logic [MASK_W-1:0] invert_r;

  logic [TW-1:0] rise_r [NUM_CHANNELS];
  logic [TW-1:0] fall_r [NUM_CHANNELS];

  logic [TW-1:0]      period_r, width_r;
  logic [ACC_W-1:0]   acc_lo_r, acc_span_r;
  logic [FRAC_W-1:0]  min_sh_r, span_sh_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CH_IN_W-1:0] ch_r;
  logic [TW-1:0]      span_r, rem_r;
  logic [DUTY_W-1:0]  dlo_r, quot_r;
  logic               sat_r;

  logic                 out_valid_r;
  logic [CH_IN_W-1:0]   out_channel_r;
  logic [DUTY_W-1:0]    out_duty_r;

  logic [CH_W+CH_IN_W-1:0] ch_wide;
  logic [CH_W-1:0]         ch_idx;
  logic                    ch_ok;
  logic                    take_in, mult_en, prep_en, div_en, emit_load;
  logic                    mult_last, div_last;

  logic [TW-1:0]     lo_w, span_w, num_w;
  logic [DIVD_W-1:0] num_ext, divd_w;
  logic [TW:0]       trial_w;
  logic              trial_ge;
  logic [DUTY_W-1:0] duty_raw, duty_fin;

  assign ch_wide = {{CH_W{1'b0}}, in_channel};
  assign ch_idx = ch_wide[CH_W-1:0];
  assign ch_ok = ch_wide < (CH_W + CH_IN_W)'(NUM_CHANNELS);

  assign mult_last = cnt_r == CNT_W'(MUL_STEPS - 1);
  assign div_last = cnt_r == CNT_W'(DIV_STEPS - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && ch_ok && in_level_high) state_nxt = ST_MULT;
      end
      ST_MULT: begin
        if (mult_last) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = (num_w >= span_w) ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    mult_en = 1'b0;
    prep_en = 1'b0;
    div_en = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_MULT: mult_en = 1'b1;
      ST_PREP: prep_en = 1'b1;
      ST_DIV:  div_en = 1'b1;
      ST_EMIT: emit_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign take_in = in_valid && !in_stall && ch_ok;

  // products of period and the two fractions, shifted down by the fraction width
  assign lo_w = acc_lo_r[ACC_W-1:FRAC_W];
  assign span_w = acc_span_r[ACC_W-1:FRAC_W];
  assign num_w = (width_r > lo_w) ? (width_r - lo_w) : '0;

  // num times 25600 = num * (2^14 + 2^13 + 2^10)
  assign num_ext = DIVD_W'(num_w);
  assign divd_w = (num_ext << 14) + (num_ext << 13) + (num_ext << 10);

  assign trial_w = {rem_r, dlo_r[DUTY_W-1]};
  assign trial_ge = trial_w >= {1'b0, span_r};

  assign duty_raw = sat_r ? FULL_SCALE : quot_r;
  assign duty_fin = invert_r[ch_r] ? (FULL_SCALE - duty_raw) : duty_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_frac_r <= MIN_FRAC_RST;
      span_frac_r <= SPAN_FRAC_RST;
      invert_r <= INVERT_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_r[i] <= '0;
        fall_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_FRAC:  min_frac_r <= cfg_data;
          REG_SPAN_FRAC: span_frac_r <= cfg_data;
          REG_INVERT:    invert_r <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end

      if (take_in) begin
        if (in_level_high) rise_r[ch_idx] <= in_tick[TW-1:0];
        else fall_r[ch_idx] <= in_tick[TW-1:0];
      end

      if (emit_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (take_in && in_level_high) begin
      period_r <= in_tick[TW-1:0] - rise_r[ch_idx];
      width_r <= fall_r[ch_idx] - rise_r[ch_idx];
      ch_r <= in_channel;
      acc_lo_r <= '0;
      acc_span_r <= '0;
      min_sh_r <= min_frac_r;
      span_sh_r <= span_frac_r;
      cnt_r <= '0;
    end

    // msb-first shift-add multiply
    if (mult_en) begin
      acc_lo_r <= {acc_lo_r[ACC_W-2:0], 1'b0} + (min_sh_r[FRAC_W-1] ? ACC_W'(period_r) : '0);
      acc_span_r <= {acc_span_r[ACC_W-2:0], 1'b0}
                    + (span_sh_r[FRAC_W-1] ? ACC_W'(period_r) : '0);
      min_sh_r <= {min_sh_r[FRAC_W-2:0], 1'b0};
      span_sh_r <= {span_sh_r[FRAC_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end

    // num below span keeps the quotient under 2^15, so the top bits seed the remainder
    if (prep_en) begin
      sat_r <= num_w >= span_w;
      span_r <= span_w;
      rem_r <= divd_w[DIVD_W-1:DUTY_W];
      dlo_r <= divd_w[DUTY_W-1:0];
      quot_r <= '0;
      cnt_r <= '0;
    end

    if (div_en) begin
      rem_r <= trial_ge ? TW'(trial_w - {1'b0, span_r}) : trial_w[TW-1:0];
      quot_r <= {quot_r[DUTY_W-2:0], trial_ge};
      dlo_r <= {dlo_r[DUTY_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end

    if (emit_load) begin
      out_channel_r <= ch_r;
      out_duty_r <= duty_fin;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_duty = out_duty_r;

endmodule

// File: hw/rtl/rcpwm_checker.sv
// rcpwm_checker: port-level checks for rc_pwm_duty_capture and its bind
`timescale 1ns / 1ps
module rcpwm_checker #(
  parameter int NUM_CHANNELS = 4
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [rcpwm_pkg::CH_IN_W-1:0]   in_channel,
  input logic                            in_level_high,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rcpwm_pkg::CH_IN_W-1:0]   out_channel,
  input logic [rcpwm_pkg::DUTY_W-1:0]    out_duty
);
  import rcpwm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty) && $stable(out_channel))
    else $error("stalled result changed");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty <= FULL_SCALE)
    else $error("duty above full scale");

  // a rising edge on a live channel keeps the block busy
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_level_high && (32'(in_channel) < NUM_CHANNELS) |=> in_stall)
    else $error("rising edge did not start a computation");

  // a result only appears after the block was busy
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without computation");

endmodule

bind rc_pwm_duty_capture rcpwm_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_rcpwm_checker (.*);

// File: tb/sv/rc_pwm_duty_capture_tb.sv
// rc_pwm_duty_capture_tb: self-checking testbench for the rc pwm duty capture block
`timescale 1ns / 1ps
module rc_pwm_duty_capture_tb;
  import rcpwm_pkg::*;

  localparam int NUM_CH = 4;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CH_IN_W-1:0] ch;
    logic [31:0] tick;
    logic rising;
  } pwm_evt_t;

  typedef struct packed {
    logic [CH_IN_W-1:0] ch;
    logic [DUTY_W-1:0] duty;
  } duty_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CH_IN_W-1:0] in_channel = '0;
  logic [31:0] in_tick = '0;
  logic in_level_high = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_IN_W-1:0] out_channel;
  logic [DUTY_W-1:0] out_duty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FRAC_W-1:0] cfg_data = '0;

  // predictor copy of the registers and capture state
  logic [FRAC_W-1:0] min_frac = MIN_FRAC_RST;
  logic [FRAC_W-1:0] span_frac = SPAN_FRAC_RST;
  logic [MASK_W-1:0] inv_mask = INVERT_RST;
  logic [31:0] rise_tick [NUM_CH] = '{default: '0};
  logic [31:0] fall_tick [NUM_CH] = '{default: '0};

  pwm_evt_t pending_evts[$];
  pwm_evt_t cur_evt;
  duty_res_t expected_duty[$];
  logic [31:0] gen_base [NUM_CH];

  bit idle_on = 1'b1;
  int queued_total = 0;
  int edges_taken = 0;
  int duty_seen = 0;
  int settings_used = 1;
  int mismatches = 0;
  int cycle_count = 0;

  rc_pwm_duty_capture u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_channel(in_channel),
    .in_tick(in_tick),
    .in_level_high(in_level_high),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_channel(out_channel),
    .out_duty(out_duty),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DUTY_W-1:0] duty_for(logic [31:0] period, logic [31:0] width);
    logic [63:0] lo;
    logic [63:0] span;
    logic [63:0] num;
    logic [63:0] q;
    lo = (64'(period) * 64'(min_frac)) >> 16;
    span = (64'(period) * 64'(span_frac)) >> 16;
    num = (64'(width) > lo) ? (64'(width) - lo) : 64'd0;
    if (span == 64'd0) return FULL_SCALE;
    q = (num * 64'(FULL_SCALE)) / span;
    return (q > 64'(FULL_SCALE)) ? FULL_SCALE : q[DUTY_W-1:0];
  endfunction

  task automatic predict_edge(pwm_evt_t e);
    logic [DUTY_W-1:0] d;
    if (!e.rising) begin
      fall_tick[e.ch] = e.tick;
    end else begin
      d = duty_for(e.tick - rise_tick[e.ch], fall_tick[e.ch] - rise_tick[e.ch]);
      if (inv_mask[e.ch]) d = FULL_SCALE - d;
      rise_tick[e.ch] = e.tick;
      expected_duty.push_back('{ch: e.ch, duty: d});
    end
  endtask

  task automatic flag_mismatch(string what, int exp_val, int got_val);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_edge(cur_evt);
        edges_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_evts.size() != 0 && !(idle_on && $urandom_range(0, 99) < 21)) begin
          cur_evt = pending_evts.pop_front();
          in_valid <= 1'b1;
          in_channel <= cur_evt.ch;
          in_tick <= cur_evt.tick;
          in_level_high <= cur_evt.rising;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    duty_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      duty_seen++;
      if (expected_duty.size() == 0) begin
        flag_mismatch("unexpected result on channel", -1, int'(out_channel));
      end else begin
        exp_res = expected_duty.pop_front();
        if (out_channel !== exp_res.ch)
          flag_mismatch("channel", int'(exp_res.ch), int'(out_channel));
        if (out_duty !== exp_res.duty)
          flag_mismatch("duty", int'(exp_res.duty), int'(out_duty));
      end
    end
    out_stall <= rst_n && idle_on && ($urandom_range(0, 99) < 21);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run timed out with %0d results outstanding", expected_duty.size());
      $display("[rc_pwm_duty_capture] ERROR");
      $finish;
    end
  end

  task automatic add_evt(logic [CH_IN_W-1:0] ch, logic [31:0] tick, logic rising);
    pending_evts.push_back('{ch: ch, tick: tick, rising: rising});
    queued_total++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_FRAC: min_frac = data;
      REG_SPAN_FRAC: span_frac = data;
      REG_INVERT: inv_mask = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [FRAC_W-1:0] mn, logic [FRAC_W-1:0] sp,
                               logic [MASK_W-1:0] inv);
    write_reg(REG_MIN_FRAC, mn);
    write_reg(REG_SPAN_FRAC, sp);
    write_reg(REG_INVERT, {{(FRAC_W-MASK_W){1'b0}}, inv});
    settings_used++;
  endtask

  // let every request go in, every result come out, then the falling-edge tail settle
  task automatic wait_idle();
    while (edges_taken != queued_total) @(posedge clk);
    while (expected_duty.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed pulses per channel, with noise and missing falling edges
  task automatic gen_random(int n);
    int made;
    int r;
    logic [CH_IN_W-1:0] ch;
    longint unsigned per;
    longint unsigned wid;
    longint unsigned lo_t;
    longint unsigned sp_t;
    made = 0;
    while (made < n) begin
      ch = CH_IN_W'($urandom_range(0, NUM_CH - 1));
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_evt(ch, $urandom, 1'($urandom_range(0, 1)));
        made++;
      end else begin
        case ($urandom_range(0, 9))
          8: per = 64'($urandom_range(70000, 2000000));
          9: per = 64'($urandom);
          default: per = 64'($urandom_range(200, 70000));
        endcase
        lo_t = (per * min_frac) >> 16;
        sp_t = (per * span_frac) >> 16;
        case ($urandom_range(0, 9))
          0: wid = 64'($urandom_range(0, lo_t[31:0]));
          1: wid = lo_t + sp_t + 64'($urandom_range(0, 1000));
          2: wid = 64'($urandom);
          default: wid = lo_t + 64'($urandom_range(0, sp_t[31:0]));
        endcase
        if (r >= 15) begin
          add_evt(ch, gen_base[ch] + wid[31:0], 1'b0);
          made++;
        end
        add_evt(ch, gen_base[ch] + per[31:0], 1'b1);
        made++;
        gen_base[ch] = gen_base[ch] + per[31:0];
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_CH; i++) gen_base[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: zero span, normal, below minimum, saturation, wrap
    add_evt(2'd0, 32'd0, 1'b1);
    add_evt(2'd0, 32'd1500, 1'b0);
    add_evt(2'd0, 32'd20000, 1'b1);
    add_evt(2'd0, 32'd20010, 1'b0);
    add_evt(2'd0, 32'd40000, 1'b1);
    add_evt(2'd0, 32'd59990, 1'b0);
    add_evt(2'd0, 32'd60000, 1'b1);
    add_evt(2'd1, 32'd1200, 1'b0);
    add_evt(2'd1, 32'd20000, 1'b1);
    add_evt(2'd1, 32'd41000, 1'b1);
    add_evt(2'd2, 32'hFFFF_F000, 1'b1);
    add_evt(2'd2, 32'h0000_0200, 1'b0);
    add_evt(2'd2, 32'h0000_F000, 1'b1);
    add_evt(2'd3, 32'hFFFF_FFFF, 1'b0);
    add_evt(2'd3, 32'hFFFF_FFFF, 1'b1);
    add_evt(2'd3, 32'h0000_0000, 1'b0);
    add_evt(2'd3, 32'h0000_0000, 1'b1);
    gen_random(150);
    wait_idle();

    apply_setting(16'h0000, 16'hFFFF, 4'hF);
    gen_random(150);
    wait_idle();

    apply_setting(16'hFFFF, 16'h0000, 4'h0);
    gen_random(60);
    wait_idle();

    // no idling on either side for a long stretch
    idle_on = 1'b0;
    apply_setting(16'd6554, 16'd13107, 4'h9);
    gen_random(250);
    wait_idle();
    idle_on = 1'b1;

    apply_setting(FRAC_W'($urandom_range(0, 65535)), FRAC_W'($urandom_range(0, 65535)),
                  MASK_W'($urandom_range(0, 15)));
    gen_random(150);
    wait_idle();

    apply_setting(16'h0000, 16'h0001, 4'h5);
    gen_random(80);
    wait_idle();

    // a write to the unused index must leave the settings alone
    apply_setting(FRAC_W'($urandom_range(0, 8000)), FRAC_W'($urandom_range(1000, 20000)),
                  MASK_W'($urandom_range(0, 15)));
    write_reg(REG_UNUSED, FRAC_W'($urandom_range(0, 65535)));
    gen_random(150);
    wait_idle();

    apply_setting(FRAC_W'($urandom_range(0, 65535)), FRAC_W'($urandom_range(0, 65535)),
                  MASK_W'($urandom_range(0, 15)));
    gen_random(150);
    wait_idle();

    $display("covered %0d capture events and %0d duty results over %0d register settings",
             edges_taken, duty_seen, settings_used);
    if (mismatches == 0) begin
      $display("[rc_pwm_duty_capture] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[rc_pwm_duty_capture] ERROR");
    end
    $finish;
  end

endmodule
